[hw/rtl/adam_pkg.sv]
// Shared constants, types and state codes of the Adam parameter update unit.
package adam_pkg;

   localparam int NUM_PARAMS    = 64;
   localparam int INDEX_W       = 6;
   localparam int DATA_W        = 32;
   localparam int RATE_W        = 24;
   localparam int POWER_W       = 25;
   localparam int SECOND_W      = 64;
   localparam int ACC_W         = 90;
   localparam int MCAND_W       = 66;
   localparam int MPLIER_W      = 32;
   localparam int MUL_STEPS     = 32;
   localparam int DIV_W         = 96;
   localparam int DEN_W         = 50;
   localparam int DIV_STEPS     = 96;
   localparam int ROOT_W        = 32;
   localparam int SQRT_STEPS    = 32;
   localparam int STEP_W        = 41;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [POWER_W-1:0] Q24_ONE  = POWER_W'(25'h1000000);
   localparam logic [POWER_W-1:0] Q24_HALF = POWER_W'(25'h0800000);

   localparam logic [RATE_W-1:0] STEP_RATE_RESET     = 24'd838861;
   localparam logic [RATE_W-1:0] FIRST_DECAY_RESET   = 24'd15099494;
   localparam logic [RATE_W-1:0] SECOND_DECAY_RESET  = 24'd16760439;
   localparam logic [DATA_W-1:0] STABILIZER_RESET    = 32'd43;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_RATE,
      CSR_FIRST_DECAY,
      CSR_SECOND_DECAY,
      CSR_STABILIZER
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POW1,
      ST_POW2,
      ST_POWEND,
      ST_M1,
      ST_M2,
      ST_G2,
      ST_V1,
      ST_V2,
      ST_MDIV,
      ST_VDIV,
      ST_SQRT,
      ST_LRMUL,
      ST_SDIV,
      ST_FIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic accumulate;
   } mac_cmd_type;

endpackage

[hw/rtl/adam_if.sv]
// Request and response channel interfaces of the Adam parameter update unit.
interface adam_req_if;
   logic                                valid;
   logic                                ready;
   logic [adam_pkg::INDEX_W-1:0]        param_slot;
   logic signed [adam_pkg::DATA_W-1:0]  gradient;
   logic signed [adam_pkg::DATA_W-1:0]  param_value;
   logic                                new_step;

   modport source(output valid, param_slot, gradient, param_value, new_step, input ready);
   modport sink(input valid, param_slot, gradient, param_value, new_step, output ready);
endinterface

interface adam_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [adam_pkg::DATA_W-1:0]  param_out;
   logic                                saturated;

   modport source(output valid, param_out, saturated, input ready);
   modport sink(input valid, param_out, saturated, output ready);
endinterface

[hw/rtl/adam_mem.sv]
// Moment store: per-index first and second moments with valid bits for reset to zero.
module adam_mem (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rd_en,
   input  logic [adam_pkg::INDEX_W-1:0]       rd_addr,
   output logic [adam_pkg::DATA_W-1:0]        rd_first,
   output logic [adam_pkg::SECOND_W-1:0]      rd_second,
   input  logic                               wr_en,
   input  logic [adam_pkg::INDEX_W-1:0]       wr_addr,
   input  logic [adam_pkg::DATA_W-1:0]        wr_first,
   input  logic [adam_pkg::SECOND_W-1:0]      wr_second
);

   logic [adam_pkg::DATA_W-1:0]   first_mem [adam_pkg::NUM_PARAMS];
   logic [adam_pkg::SECOND_W-1:0] second_mem [adam_pkg::NUM_PARAMS];
   logic [adam_pkg::NUM_PARAMS-1:0] valid_ff;
   logic [adam_pkg::DATA_W-1:0]   first_ff;
   logic [adam_pkg::SECOND_W-1:0] second_ff;
   logic                          hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         first_mem[wr_addr]  <= wr_first;
         second_mem[wr_addr] <= wr_second;
      end
      if (rd_en) begin
         first_ff  <= first_mem[rd_addr];
         second_ff <= second_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            hit_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_first  = hit_ff ? first_ff : '0;
   assign rd_second = hit_ff ? second_ff : '0;

endmodule

[hw/rtl/adam_mac.sv]
// Bit-serial multiply-accumulate unit that consumes one multiplier bit per cycle.
module adam_mac (
   input  logic                              clock,
   input  logic                              reset,
   input  adam_pkg::mac_cmd_type             cmd,
   input  logic [adam_pkg::MCAND_W-1:0]      mcand,
   input  logic [adam_pkg::MPLIER_W-1:0]     mplier,
   output logic                              done,
   output logic [adam_pkg::ACC_W-1:0]        acc
);

   logic [adam_pkg::ACC_W-1:0]    acc_ff;
   logic [adam_pkg::ACC_W-1:0]    mcand_ff;
   logic [adam_pkg::MPLIER_W-1:0] mplier_ff;
   logic [4:0]                    count_ff;
   logic                          busy_ff;

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         if (!cmd.accumulate) begin
            acc_ff <= '0;
         end
         mcand_ff  <= {{(adam_pkg::ACC_W-adam_pkg::MCAND_W){mcand[adam_pkg::MCAND_W-1]}}, mcand};
         mplier_ff <= mplier;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            acc_ff <= acc_ff + mcand_ff;
         end
         mcand_ff  <= {mcand_ff[adam_pkg::ACC_W-2:0], 1'b0};
         mplier_ff <= {1'b0, mplier_ff[adam_pkg::MPLIER_W-1:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (cmd.start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 5'd1;
         if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign done = busy_ff && (count_ff == 5'(adam_pkg::MUL_STEPS - 1));
   assign acc  = acc_ff;

endmodule

[hw/rtl/adam_div.sv]
// Restoring divider that produces one quotient bit per cycle.
module adam_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [adam_pkg::DIV_W-1:0]     dividend,
   input  logic [adam_pkg::DEN_W-1:0]     divisor,
   output logic                           done,
   output logic [adam_pkg::DIV_W-1:0]     quotient
);

   logic [adam_pkg::DIV_W-1:0] dq_ff;
   logic [adam_pkg::DEN_W-1:0] rem_ff;
   logic [adam_pkg::DEN_W-1:0] den_ff;
   logic [adam_pkg::DEN_W:0]   trial;
   logic [adam_pkg::DEN_W:0]   diff;
   logic                       ge;
   logic [6:0]                 count_ff;
   logic                       busy_ff;

   assign trial = {rem_ff, dq_ff[adam_pkg::DIV_W-1]};
   assign ge    = trial >= {1'b0, den_ff};
   assign diff  = trial - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (start) begin
         dq_ff  <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= ge ? diff[adam_pkg::DEN_W-1:0] : trial[adam_pkg::DEN_W-1:0];
         dq_ff  <= {dq_ff[adam_pkg::DIV_W-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 7'd1;
         if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign done     = busy_ff && (count_ff == 7'(adam_pkg::DIV_STEPS - 1));
   assign quotient = dq_ff;

endmodule

[hw/rtl/adam_sqrt.sv]
// Integer square root that retires two radicand bits per cycle.
module adam_sqrt (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [adam_pkg::SECOND_W-1:0]     radicand,
   output logic                              done,
   output logic [adam_pkg::ROOT_W-1:0]       root
);

   logic [adam_pkg::SECOND_W-1:0] x_ff;
   logic [adam_pkg::ROOT_W-1:0]   root_ff;
   logic [adam_pkg::ROOT_W+2:0]   rem_ff;
   logic [adam_pkg::ROOT_W+2:0]   shifted;
   logic [adam_pkg::ROOT_W+2:0]   trial;
   logic                          ge;
   logic [4:0]                    count_ff;
   logic                          busy_ff;

   assign shifted = {rem_ff[adam_pkg::ROOT_W:0], x_ff[adam_pkg::SECOND_W-1 -: 2]};
   assign trial   = {1'b0, root_ff, 2'b01};
   assign ge      = shifted >= trial;

   always_ff @(posedge clock) begin
      if (start) begin
         x_ff    <= radicand;
         root_ff <= '0;
         rem_ff  <= '0;
      end else if (busy_ff) begin
         rem_ff  <= ge ? shifted - trial : shifted;
         root_ff <= {root_ff[adam_pkg::ROOT_W-2:0], ge};
         x_ff    <= {x_ff[adam_pkg::SECOND_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else if (start) begin
         busy_ff  <= 1'b1;
         count_ff <= '0;
      end else if (busy_ff) begin
         count_ff <= count_ff + 5'd1;
         if (done) begin
            busy_ff <= 1'b0;
         end
      end
   end

   assign done = busy_ff && (count_ff == 5'(adam_pkg::SQRT_STEPS - 1));
   assign root = root_ff;

endmodule

[hw/rtl/adam_optimizer_update_top.sv]
// Top level of the Adam parameter update unit: sequencer, settings and result register.
// The unit takes one request at a time and returns exactly one result for it. A request
// with new_step set first advances the two bias-correction powers. The time per request is
// set by the shared bit-serial units: each multiply runs in the multiply accumulator, each
// of the three divisions in the restoring divider, and the square root in its own unit.
// A finished result waits in an output register, so the next request is taken while it is
// still unread. Moments reset to zero through per-index valid bits, so no clearing pass
// follows reset. The user is to write settings through the csr port only while idle; the
// block itself does not enforce this.
module adam_optimizer_update_top (
   input  logic                                  clock,
   input  logic                                  reset,
   adam_req_if.sink                              req_channel,
   adam_rsp_if.source                            rsp_channel,
   input  logic                                  csr_write_enable,
   input  logic [adam_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [adam_pkg::DATA_W-1:0]           csr_write_data
);

   adam_pkg::state_type state_ff, state_in;

   logic [adam_pkg::RATE_W-1:0]   lr_ff, b1_ff, b2_ff;
   logic [adam_pkg::DATA_W-1:0]   stab_ff;
   logic [adam_pkg::POWER_W-1:0]  p1_ff, p2_ff;

   logic [adam_pkg::INDEX_W-1:0]  idx_ff;
   logic [adam_pkg::DATA_W-1:0]   g_ff, pv_ff, m_ff;
   logic                          oor_ff, run_ff;
   logic [adam_pkg::SECOND_W-1:0] g2_ff, v_ff, mhat_ff;
   logic [adam_pkg::DEN_W-1:0]    den_ff;
   logic [adam_pkg::STEP_W-1:0]   mag_ff;

   logic                          rsp_valid_ff, rsp_saturated_ff;
   logic [adam_pkg::DATA_W-1:0]   rsp_param_out_ff;

   logic                          accept, oor_in, unit_state, start, unit_done, load_rsp;
   adam_pkg::mac_cmd_type         mac_cmd;
   logic [adam_pkg::MCAND_W-1:0]  mcand;
   logic [adam_pkg::MPLIER_W-1:0] mplier;
   logic                          mac_done, div_start, div_done, sqrt_start, sqrt_done;
   logic [adam_pkg::ACC_W-1:0]    acc;
   logic [adam_pkg::DIV_W-1:0]    dividend, quotient;
   logic [adam_pkg::DEN_W-1:0]    divisor;
   logic [adam_pkg::ROOT_W-1:0]   root;
   logic [adam_pkg::DATA_W-1:0]   mem_first;
   logic [adam_pkg::SECOND_W-1:0] mem_second;
   logic                          mem_wr;

   logic [49:0]                   pow_sum;
   logic [adam_pkg::ACC_W-1:0]    round_sum;
   logic [adam_pkg::POWER_W-1:0]  d1, d2, c1, c2;
   logic [adam_pkg::DATA_W-1:0]   gmag, mmag;
   logic [adam_pkg::SECOND_W-1:0] div_sat, vhat_in;
   logic [adam_pkg::STEP_W-1:0]   mag_in;
   logic [42:0]                   res;
   logic                          sat_hi, sat_lo;
   logic [adam_pkg::DATA_W-1:0]   param_out_in;

   assign accept  = req_channel.valid && req_channel.ready;
   assign oor_in  = 32'(req_channel.param_slot) >= adam_pkg::NUM_PARAMS;

   assign pow_sum   = acc[49:0] + 50'(adam_pkg::Q24_HALF);
   assign round_sum = acc + adam_pkg::ACC_W'(adam_pkg::Q24_HALF);
   assign d1        = adam_pkg::Q24_ONE - p1_ff;
   assign d2        = adam_pkg::Q24_ONE - p2_ff;
   assign c1        = adam_pkg::Q24_ONE - {1'b0, b1_ff};
   assign c2        = adam_pkg::Q24_ONE - {1'b0, b2_ff};
   assign gmag      = g_ff[31] ? (~g_ff + 32'd1) : g_ff;
   assign mmag      = m_ff[31] ? (~m_ff + 32'd1) : m_ff;
   assign div_sat   = (quotient[95:64] != '0) ? '1 : quotient[63:0];
   assign vhat_in   = (d2 == '0) ? v_ff : div_sat;
   assign mag_in    = (den_ff == '0) ? '0 :
                      (quotient[95:40] != '0) ? {1'b1, 40'b0} : quotient[40:0];

   assign res    = m_ff[31] ? ({{11{pv_ff[31]}}, pv_ff} + {2'b00, mag_ff})
                            : ({{11{pv_ff[31]}}, pv_ff} - {2'b00, mag_ff});
   assign sat_hi = !oor_ff && !res[42] && (res[41:31] != 11'h000);
   assign sat_lo = !oor_ff && res[42] && (res[41:31] != 11'h7FF);
   assign param_out_in = oor_ff ? pv_ff :
                         sat_hi ? 32'h7FFF_FFFF :
                         sat_lo ? 32'h8000_0000 : res[31:0];

   assign unit_done = mac_done || div_done || sqrt_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff   <= adam_pkg::STEP_RATE_RESET;
         b1_ff   <= adam_pkg::FIRST_DECAY_RESET;
         b2_ff   <= adam_pkg::SECOND_DECAY_RESET;
         stab_ff <= adam_pkg::STABILIZER_RESET;
      end else if (csr_write_enable) begin
         case (adam_pkg::csr_index_type'(csr_index))
            adam_pkg::CSR_STEP_RATE:     lr_ff   <= csr_write_data[adam_pkg::RATE_W-1:0];
            adam_pkg::CSR_FIRST_DECAY:   b1_ff   <= csr_write_data[adam_pkg::RATE_W-1:0];
            adam_pkg::CSR_SECOND_DECAY:  b2_ff   <= csr_write_data[adam_pkg::RATE_W-1:0];
            adam_pkg::CSR_STABILIZER:    stab_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         adam_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_channel.new_step) begin
                  state_in = adam_pkg::ST_POW1;
               end else if (oor_in) begin
                  state_in = adam_pkg::ST_DONE;
               end else begin
                  state_in = adam_pkg::ST_M1;
               end
            end
         end
         adam_pkg::ST_POW1:   if (unit_done) state_in = adam_pkg::ST_POW2;
         adam_pkg::ST_POW2:   if (unit_done) state_in = adam_pkg::ST_POWEND;
         adam_pkg::ST_POWEND: state_in = oor_ff ? adam_pkg::ST_DONE : adam_pkg::ST_M1;
         adam_pkg::ST_M1:     if (unit_done) state_in = adam_pkg::ST_M2;
         adam_pkg::ST_M2:     if (unit_done) state_in = adam_pkg::ST_G2;
         adam_pkg::ST_G2:     if (unit_done) state_in = adam_pkg::ST_V1;
         adam_pkg::ST_V1:     if (unit_done) state_in = adam_pkg::ST_V2;
         adam_pkg::ST_V2:     if (unit_done) state_in = adam_pkg::ST_MDIV;
         adam_pkg::ST_MDIV:   if (unit_done) state_in = adam_pkg::ST_VDIV;
         adam_pkg::ST_VDIV:   if (unit_done) state_in = adam_pkg::ST_SQRT;
         adam_pkg::ST_SQRT:   if (unit_done) state_in = adam_pkg::ST_LRMUL;
         adam_pkg::ST_LRMUL:  if (unit_done) state_in = adam_pkg::ST_SDIV;
         adam_pkg::ST_SDIV:   if (unit_done) state_in = adam_pkg::ST_FIN;
         adam_pkg::ST_FIN:    state_in = adam_pkg::ST_DONE;
         adam_pkg::ST_DONE:   if (load_rsp) state_in = adam_pkg::ST_IDLE;
         default:             state_in = adam_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      unit_state = 1'b0;
      mac_cmd    = '0;
      mcand      = '0;
      mplier     = '0;
      div_start  = 1'b0;
      dividend   = '0;
      divisor    = '0;
      sqrt_start = 1'b0;
      mem_wr     = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         adam_pkg::ST_POW1: begin
            unit_state = 1'b1;
            mcand      = {41'b0, p1_ff};
            mplier     = {8'b0, b1_ff};
         end
         adam_pkg::ST_POW2: begin
            unit_state = 1'b1;
            mcand      = {41'b0, p2_ff};
            mplier     = {8'b0, b2_ff};
         end
         adam_pkg::ST_M1: begin
            unit_state = 1'b1;
            mcand      = {{34{mem_first[31]}}, mem_first};
            mplier     = {8'b0, b1_ff};
         end
         adam_pkg::ST_M2: begin
            unit_state         = 1'b1;
            mac_cmd.accumulate = 1'b1;
            mcand              = {{34{g_ff[31]}}, g_ff};
            mplier             = {7'b0, c1};
         end
         adam_pkg::ST_G2: begin
            unit_state = 1'b1;
            mcand      = {34'b0, gmag};
            mplier     = gmag;
         end
         adam_pkg::ST_V1: begin
            unit_state = 1'b1;
            mcand      = {2'b0, mem_second};
            mplier     = {8'b0, b2_ff};
         end
         adam_pkg::ST_V2: begin
            unit_state         = 1'b1;
            mac_cmd.accumulate = 1'b1;
            mcand              = {2'b0, g2_ff};
            mplier             = {7'b0, c2};
         end
         adam_pkg::ST_MDIV: begin
            unit_state = 1'b1;
            div_start  = start;
            dividend   = {40'b0, mmag, 24'b0};
            divisor    = {25'b0, d1};
         end
         adam_pkg::ST_VDIV: begin
            unit_state = 1'b1;
            div_start  = start;
            dividend   = {8'b0, v_ff, 24'b0};
            divisor    = {25'b0, d2};
         end
         adam_pkg::ST_SQRT: begin
            unit_state = 1'b1;
            sqrt_start = start;
         end
         adam_pkg::ST_LRMUL: begin
            unit_state = 1'b1;
            mcand      = {2'b0, mhat_ff};
            mplier     = {8'b0, lr_ff};
         end
         adam_pkg::ST_SDIV: begin
            unit_state = 1'b1;
            div_start  = start;
            dividend   = {acc[87:0], 8'b0};
            divisor    = den_ff;
         end
         adam_pkg::ST_FIN: begin
            mem_wr = 1'b1;
         end
         adam_pkg::ST_DONE: begin
            load_rsp = !rsp_valid_ff || rsp_channel.ready;
         end
         default: ;
      endcase
      mac_cmd.start = start && !div_start && !sqrt_start;
   end

   assign start = unit_state && !run_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= adam_pkg::ST_IDLE;
         run_ff   <= 1'b0;
         p1_ff    <= adam_pkg::Q24_ONE;
         p2_ff    <= adam_pkg::Q24_ONE;
      end else begin
         state_ff <= state_in;
         if (start) begin
            run_ff <= 1'b1;
         end else if (unit_done) begin
            run_ff <= 1'b0;
         end
         if (start && (state_ff == adam_pkg::ST_POW2)) begin
            p1_ff <= pow_sum[48:24];
         end
         if (state_ff == adam_pkg::ST_POWEND) begin
            p2_ff <= pow_sum[48:24];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff <= req_channel.param_slot;
         g_ff   <= req_channel.gradient;
         pv_ff  <= req_channel.param_value;
         oor_ff <= oor_in;
      end
      if (start) begin
         case (state_ff)
            adam_pkg::ST_G2:    m_ff    <= round_sum[55:24];
            adam_pkg::ST_V1:    g2_ff   <= acc[63:0];
            adam_pkg::ST_MDIV:  v_ff    <= round_sum[87:24];
            adam_pkg::ST_VDIV:  mhat_ff <= (d1 == '0) ? {32'b0, mmag} : div_sat;
            adam_pkg::ST_LRMUL: den_ff  <= {2'b0, root, 16'b0} + {18'b0, stab_ff};
            default: ;
         endcase
      end
      if (state_ff == adam_pkg::ST_FIN) begin
         mag_ff <= mag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_channel.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_param_out_ff <= param_out_in;
         rsp_saturated_ff <= sat_hi || sat_lo;
      end
   end

   assign req_channel.ready     = state_ff == adam_pkg::ST_IDLE;
   assign rsp_channel.valid     = rsp_valid_ff;
   assign rsp_channel.param_out = rsp_param_out_ff;
   assign rsp_channel.saturated = rsp_saturated_ff;

   adam_mem u_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (req_channel.param_slot),
      .rd_first  (mem_first),
      .rd_second (mem_second),
      .wr_en     (mem_wr),
      .wr_addr   (idx_ff),
      .wr_first  (m_ff),
      .wr_second (v_ff)
   );

   adam_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .cmd    (mac_cmd),
      .mcand  (mcand),
      .mplier (mplier),
      .done   (mac_done),
      .acc    (acc)
   );

   adam_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   adam_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (vhat_in),
      .done     (sqrt_done),
      .root     (root)
   );

`ifndef NO_ASSERTIONS
   // An accepted request always moves the sequencer out of idle.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != adam_pkg::ST_IDLE)
      else $error("Accepted request left the sequencer idle.");

   // Only one arithmetic unit finishes at a time.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({mac_done, div_done, sqrt_done}))
      else $error("More than one arithmetic unit finished in one cycle.");

   // The bias-correction powers never grow past one.
   assert property (@(posedge clock) disable iff (reset)
      (p1_ff <= adam_pkg::Q24_ONE) && (p2_ff <= adam_pkg::Q24_ONE))
      else $error("Bias-correction power exceeds one.");

   // A clipped result sits at one end of the range.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_saturated_ff |->
         (rsp_param_out_ff == 32'h7FFF_FFFF || rsp_param_out_ff == 32'h8000_0000))
      else $error("Saturated result is not at a range limit.");
`endif

endmodule

[dv/testbench.sv]
// Self-checking testbench for the Adam parameter update unit with its own update predictor.
module testbench;

   typedef struct {
      logic [adam_pkg::INDEX_W-1:0]       idx;
      logic signed [adam_pkg::DATA_W-1:0] grad;
      logic signed [adam_pkg::DATA_W-1:0] value;
      logic                               new_step;
   } update_req_type;

   typedef struct {
      logic signed [adam_pkg::DATA_W-1:0] value;
      logic                               clipped;
   } update_rsp_type;

   localparam logic [63:0] ONE_Q24  = 64'h1000000;
   localparam logic [63:0] HALF_Q24 = 64'h800000;
   localparam logic [63:0] STEP_CAP = 64'h100_0000_0000;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic [adam_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [adam_pkg::DATA_W-1:0] csr_write_data;

   adam_req_if req_bus();
   adam_rsp_if rsp_bus();

   adam_optimizer_update_top dut (
      .clock(clock),
      .reset(reset),
      .req_channel(req_bus),
      .rsp_channel(rsp_bus),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   // Predictor state and settings.
   logic [adam_pkg::RATE_W-1:0] step_rate;
   logic [adam_pkg::RATE_W-1:0] first_decay;
   logic [adam_pkg::RATE_W-1:0] second_decay;
   logic [adam_pkg::DATA_W-1:0] stabilizer;
   logic signed [adam_pkg::DATA_W-1:0] first_mom [adam_pkg::NUM_PARAMS];
   logic [63:0] second_mom [adam_pkg::NUM_PARAMS];
   logic [adam_pkg::POWER_W-1:0] first_power;
   logic [adam_pkg::POWER_W-1:0] second_power;

   update_req_type pending_requests[$];
   update_rsp_type expected_updates[$];
   update_req_type current_request;
   int burst_left;
   int gap_left;
   int accepted_count;
   int mismatch_count;
   logic hold_off;
   logic [15:0] ready_pattern;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] bias_correct(logic [63:0] x, logic [63:0] d);
      logic [127:0] wide;
      if (x / d >= STEP_CAP) begin
         return '1;
      end
      wide = (128'(x) << 24) / 128'(d);
      return wide[63:0];
   endfunction

   function automatic update_rsp_type predict_update(update_req_type r);
      longint signed acc;
      longint signed m;
      longint signed res;
      logic [127:0] wide;
      logic [63:0] gmag, g2, v, mmag, mhat, vhat, den, mag, d1, d2, pw1, pw2;
      logic [31:0] root;
      logic [31:0] trial;
      logic neg;
      update_rsp_type o;
      if (r.new_step) begin
         pw1 = (64'(first_power) * 64'(first_decay) + HALF_Q24) >> 24;
         pw2 = (64'(second_power) * 64'(second_decay) + HALF_Q24) >> 24;
         first_power = pw1[adam_pkg::POWER_W-1:0];
         second_power = pw2[adam_pkg::POWER_W-1:0];
      end
      acc = longint'(first_decay) * longint'(first_mom[r.idx])
          + longint'(ONE_Q24 - 64'(first_decay)) * longint'(r.grad);
      m = (acc + longint'(HALF_Q24)) >>> 24;
      first_mom[r.idx] = m[31:0];
      gmag = (r.grad < 0) ? 64'(-longint'(r.grad)) : 64'(longint'(r.grad));
      g2 = gmag * gmag;
      wide = 128'(second_mom[r.idx]) * 128'(second_decay)
           + 128'(g2) * 128'(ONE_Q24 - 64'(second_decay)) + 128'(HALF_Q24);
      v = wide[87:24];
      second_mom[r.idx] = v;
      d1 = ONE_Q24 - 64'(first_power);
      d2 = ONE_Q24 - 64'(second_power);
      neg = m < 0;
      mmag = neg ? 64'(-m) : 64'(m);
      mhat = (d1 == 0) ? mmag : bias_correct(mmag, d1);
      vhat = (d2 == 0) ? v : bias_correct(v, d2);
      root = '0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (32'd1 << b);
         if (64'(trial) * 64'(trial) <= vhat) begin
            root = trial;
         end
      end
      den = (64'(root) << 16) + 64'(stabilizer);
      if (den == 0) begin
         mag = '0;
      end else begin
         wide = ((128'(mhat) * 128'(step_rate)) << 8) / 128'(den);
         mag = (wide > 128'(STEP_CAP)) ? STEP_CAP : wide[63:0];
      end
      res = neg ? longint'(r.value) + longint'(mag) : longint'(r.value) - longint'(mag);
      o.clipped = 1'b0;
      if (res > 64'sd2147483647) begin
         res = 64'sd2147483647;
         o.clipped = 1'b1;
      end else if (res < -64'sd2147483648) begin
         res = -64'sd2147483648;
         o.clipped = 1'b1;
      end
      o.value = res[31:0];
      return o;
   endfunction

   // Request driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
         burst_left = 4;
         gap_left = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            expected_updates.insert(expected_updates.size(), predict_update(current_request));
            accepted_count++;
         end
         if (req_bus.valid && !req_bus.ready) begin
            req_bus.valid <= 1'b1;
         end else if (gap_left > 0) begin
            gap_left--;
            req_bus.valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            current_request = pending_requests.pop_front();
            req_bus.param_slot <= current_request.idx;
            req_bus.gradient <= current_request.grad;
            req_bus.param_value <= current_request.value;
            req_bus.new_step <= current_request.new_step;
            req_bus.valid <= 1'b1;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 700);
            end
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Response monitor and receiver stall pattern.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         ready_pattern = 16'hffff;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_updates.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("Unexpected response: param_out=%0d saturated=%0b",
                           rsp_bus.param_out, rsp_bus.saturated);
               end
            end else begin
               update_rsp_type want;
               want = expected_updates.pop_front();
               if (rsp_bus.param_out !== want.value || rsp_bus.saturated !== want.clipped) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("Mismatch: param_out exp %0d got %0d, saturated exp %0b got %0b",
                              want.value, rsp_bus.param_out, want.clipped, rsp_bus.saturated);
                  end
               end
            end
         end
         ready_pattern = {ready_pattern[14:0], ready_pattern[15]};
         if ($urandom_range(0, 63) == 0) begin
            ready_pattern = ($urandom_range(0, 2) == 0) ? 16'hffff : 16'($urandom);
         end
         rsp_bus.ready <= !hold_off && ready_pattern[0];
      end
   end

   // A long receiver hold-off fills the block so that it stalls its input.
   initial begin
      hold_off = 1'b0;
      wait (accepted_count >= 30);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (4000) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin
      #(20 * 6_000_000);
      $display("FAIL");
      $finish;
   end

   task automatic write_reg(adam_pkg::csr_index_type idx, logic [adam_pkg::DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         adam_pkg::CSR_STEP_RATE:    step_rate = data[adam_pkg::RATE_W-1:0];
         adam_pkg::CSR_FIRST_DECAY:  first_decay = data[adam_pkg::RATE_W-1:0];
         adam_pkg::CSR_SECOND_DECAY: second_decay = data[adam_pkg::RATE_W-1:0];
         adam_pkg::CSR_STABILIZER:   stabilizer = data;
         default: ;
      endcase
   endtask

   task automatic write_settings(logic [31:0] lr, logic [31:0] b1, logic [31:0] b2,
                                 logic [31:0] eps);
      write_reg(adam_pkg::CSR_STEP_RATE, lr);
      write_reg(adam_pkg::CSR_FIRST_DECAY, b1);
      write_reg(adam_pkg::CSR_SECOND_DECAY, b2);
      write_reg(adam_pkg::CSR_STABILIZER, eps);
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic add_request(int idx, logic [31:0] grad, logic [31:0] value, logic step);
      update_req_type r;
      r.idx = idx[adam_pkg::INDEX_W-1:0];
      r.grad = grad;
      r.value = value;
      r.new_step = step;
      pending_requests.insert(pending_requests.size(), r);
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_requests.size() != 0 || req_bus.valid || expected_updates.size() != 0);
   endtask

   function automatic logic [31:0] random_q16();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return ($urandom_range(0, 1) == 0) ? 32'h7fffffff : 32'h80000000;
         2: return 32'($urandom_range(0, 8)) - 32'd4;
         default: return 32'(signed'(32'($urandom_range(0, 20'hfffff))) - 32'sh80000);
      endcase
   endfunction

   task automatic add_random_requests(int count);
      int hot;
      hot = $urandom_range(0, 63);
      for (int k = 0; k < count; k++) begin
         add_request(($urandom_range(0, 2) == 0) ? hot : $urandom_range(0, 63),
                     random_q16(), random_q16(), $urandom_range(0, 9) == 0);
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = adam_pkg::CSR_STEP_RATE;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.param_slot = '0;
      req_bus.gradient = '0;
      req_bus.param_value = '0;
      req_bus.new_step = 1'b0;
      rsp_bus.ready = 1'b0;
      accepted_count = 0;
      mismatch_count = 0;
      step_rate = adam_pkg::STEP_RATE_RESET;
      first_decay = adam_pkg::FIRST_DECAY_RESET;
      second_decay = adam_pkg::SECOND_DECAY_RESET;
      stabilizer = adam_pkg::STABILIZER_RESET;
      first_power = adam_pkg::Q24_ONE;
      second_power = adam_pkg::Q24_ONE;
      for (int i = 0; i < adam_pkg::NUM_PARAMS; i++) begin
         first_mom[i] = '0;
         second_mom[i] = '0;
      end
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // The powers are still one, so both bias corrections are skipped at first.
      add_request(0, 32'h00010000, 32'h00020000, 1'b0);
      add_request(63, 32'h80000000, 32'h7fffffff, 1'b0);
      add_request(1, 32'h7fffffff, 32'h80000000, 1'b0);
      add_request(2, 32'h0, 32'h0, 1'b0);
      add_request(0, 32'hffffffff, 32'hffffffff, 1'b1);
      add_request(63, 32'h80000000, 32'h7ffffff0, 1'b0);
      add_request(1, 32'h7fffffff, 32'h80000010, 1'b0);
      add_request(3, 32'h00000001, 32'h12345678, 1'b1);
      add_request(4, 32'hfff00000, 32'h0, 1'b1);
      add_request(5, 32'h55555555, 32'haaaaaaaa, 1'b0);
      add_request(6, 32'haaaaaaaa, 32'h55555555, 1'b0);
      wait_idle();

      // No stabilizer and a zero gradient on a fresh index give a zero denominator.
      write_settings(32'hffffff, 32'h0, 32'h0, 32'h0);
      add_request(10, 32'h0, 32'h00030000, 1'b0);
      add_request(11, 32'h00008000, 32'h7fffffff, 1'b1);
      add_request(12, 32'h80000000, 32'h7fffffff, 1'b0);
      add_request(13, 32'h7fffffff, 32'h80000000, 1'b1);
      add_request(10, 32'h0, 32'h0, 1'b0);
      wait_idle();

      write_settings(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      add_request(20, 32'h7fffffff, 32'h0, 1'b1);
      add_request(21, 32'h80000000, 32'h0, 1'b0);
      add_request(22, 32'h00010000, 32'h7fffffff, 1'b1);
      add_random_requests(90);
      wait_idle();

      write_settings(32'h0, 32'h800000, 32'hff0000, 32'h1);
      add_random_requests(90);
      wait_idle();

      for (int phase = 0; phase < 3; phase++) begin
         write_settings($urandom, $urandom, 32'hff0000 | 32'($urandom_range(0, 16'hffff)),
                        $urandom_range(0, 1000));
         add_random_requests(65);
         wait_idle();
      end

      repeat (700) @(posedge clock);
      if (mismatch_count == 0 && expected_updates.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end
endmodule

[filelist.f]
hw/rtl/adam_pkg.sv
hw/rtl/adam_if.sv
hw/rtl/adam_mem.sv
hw/rtl/adam_mac.sv
hw/rtl/adam_div.sv
hw/rtl/adam_sqrt.sv
hw/rtl/adam_optimizer_update_top.sv
dv/testbench.sv
